// ===== hw/rtl/lecm_pkg.sv =====
// Shared constants, codes, types and the command text table for the line matcher.
`timescale 1ns / 1ps

package lecm_pkg;

  localparam int LINE_CAPACITY = 32;
  localparam int LEN_W         = $clog2(LINE_CAPACITY);
  localparam int NUM_CMD       = 5;

  // action codes
  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_ECHO     = 3'd1;
  localparam logic [2:0] ACT_ERASE    = 3'd2;
  localparam logic [2:0] ACT_PROMPT   = 3'd3;
  localparam logic [2:0] ACT_DONE     = 3'd4;
  localparam logic [2:0] ACT_TOO_LONG = 3'd5;

  // response codes
  localparam logic [2:0] RSP_NONE         = 3'd0;
  localparam logic [2:0] RSP_SWITCHED_ON  = 3'd1;
  localparam logic [2:0] RSP_SWITCHED_OFF = 3'd2;
  localparam logic [2:0] RSP_STATE_ON     = 3'd3;
  localparam logic [2:0] RSP_STATE_OFF    = 3'd4;
  localparam logic [2:0] RSP_HELP         = 3'd5;
  localparam logic [2:0] RSP_UNKNOWN      = 3'd6;

  // command indexes
  localparam logic [2:0] CMD_LED_ON     = 3'd0;
  localparam logic [2:0] CMD_LED_OFF    = 3'd1;
  localparam logic [2:0] CMD_LED_TOGGLE = 3'd2;
  localparam logic [2:0] CMD_STATUS     = 3'd3;
  localparam logic [2:0] CMD_HELP       = 3'd4;

  // special characters
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_BS  = 8'd8;
  localparam logic [7:0] CH_DEL = 8'd127;

  // command text, first character in the top byte, zero padded to 16 bytes
  localparam logic [127:0] CMD_TEXT [NUM_CMD] = '{
    {"led on",     80'h0},
    {"led off",    72'h0},
    {"led toggle", 48'h0},
    {"status",     80'h0},
    {"help",       96'h0}
  };

  localparam logic [LEN_W-1:0] CMD_LEN [NUM_CMD] = '{
    LEN_W'(6), LEN_W'(7), LEN_W'(10), LEN_W'(6), LEN_W'(4)
  };

  typedef struct packed {
    logic latch;       // capture the incoming character
    logic scan_start;  // clear the scan index and set every candidate mask bit
    logic rd_issue;    // read the line store at the scan index
    logic cmp;         // compare the read character against the commands
    logic emit;        // load the result and update the line state
  } lecm_cmd_t;

  typedef struct packed {
    logic need_scan;   // incoming character ends a non-empty line
    logic scan_stop;   // current compare is the last one of the line
    logic out_free;    // result register can take a new transaction
  } lecm_status_t;

  function automatic logic [7:0] cmd_char(input logic [2:0] k, input logic [3:0] idx);
    logic [127:0] txt;
    txt = CMD_TEXT[0];
    case (k)
      CMD_LED_ON:     txt = CMD_TEXT[0];
      CMD_LED_OFF:    txt = CMD_TEXT[1];
      CMD_LED_TOGGLE: txt = CMD_TEXT[2];
      CMD_STATUS:     txt = CMD_TEXT[3];
      CMD_HELP:       txt = CMD_TEXT[4];
      default:        txt = '0;
    endcase
    return txt[{~idx, 3'b000} +: 8];
  endfunction

endpackage

// ===== hw/rtl/lecm_ctrl.sv =====
// Sequencer for character handling and the command compare scan.
`timescale 1ns / 1ps

module lecm_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  lecm_pkg::lecm_status_t status,
  output lecm_pkg::lecm_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADDR = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    cmd.latch      = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (status.need_scan) begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_ADDR;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_CMP;
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = status.scan_stop ? S_EMIT : S_ADDR;
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/lecm_dp.sv =====
// Datapath: line store, length and LED state, compare scan and result register.
`timescale 1ns / 1ps

module lecm_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [7:0]             in_rx_char,
  input  lecm_pkg::lecm_cmd_t    cmd,
  output lecm_pkg::lecm_status_t status,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             out_action,
  output logic [7:0]             out_echo_char,
  output logic [2:0]             out_response,
  output logic                   out_led_drive
);

  localparam int LW = lecm_pkg::LEN_W;

  logic [7:0]    line_mem [lecm_pkg::LINE_CAPACITY];
  logic [7:0]    rd_data_r;
  logic [7:0]    ch_r;
  logic [LW-1:0] len_r, len_nxt;
  logic          led_r, led_nxt;
  logic [LW-1:0] pos_r;
  logic [lecm_pkg::NUM_CMD-1:0] cand_r, cand_nxt;
  logic          out_valid_r;
  logic [2:0]    act_r, act_nxt;
  logic [7:0]    echo_r, echo_nxt;
  logic [2:0]    rsp_r, rsp_nxt;
  logic          led_out_r;
  logic          store_wr;
  logic          is_enter, is_erase, in_enter;
  logic [lecm_pkg::NUM_CMD-1:0] hit;

  assign in_enter = (in_rx_char == lecm_pkg::CH_CR) || (in_rx_char == lecm_pkg::CH_LF);
  assign is_enter = (ch_r == lecm_pkg::CH_CR) || (ch_r == lecm_pkg::CH_LF);
  assign is_erase = (ch_r == lecm_pkg::CH_BS) || (ch_r == lecm_pkg::CH_DEL);

  assign status.need_scan = in_enter && (len_r != '0);
  assign status.scan_stop = (rd_data_r == 8'd0) || ((pos_r + LW'(1)) == len_r);
  assign status.out_free  = !out_valid_r || !out_stall;

  // candidate mask narrows by one character per compare step
  always_comb begin
    for (int k = 0; k < lecm_pkg::NUM_CMD; k++) begin
      cand_nxt[k] = cand_r[k] && (pos_r < lecm_pkg::CMD_LEN[k]) &&
                    (rd_data_r == lecm_pkg::cmd_char(3'(k), pos_r[3:0]));
      hit[k]      = cand_r[k] && (pos_r == lecm_pkg::CMD_LEN[k]);
    end
  end

  always_comb begin
    len_nxt  = len_r;
    led_nxt  = led_r;
    act_nxt  = lecm_pkg::ACT_NONE;
    echo_nxt = 8'd0;
    rsp_nxt  = lecm_pkg::RSP_NONE;
    store_wr = 1'b0;
    if (is_enter) begin
      if (len_r != '0) begin
        len_nxt = '0;
        act_nxt = lecm_pkg::ACT_DONE;
        // pos_r holds the length of the text up to the first zero byte
        if (pos_r == '0) begin
          rsp_nxt = lecm_pkg::RSP_NONE;
        end else if (hit[0]) begin
          led_nxt = 1'b1;
          rsp_nxt = lecm_pkg::RSP_SWITCHED_ON;
        end else if (hit[1]) begin
          led_nxt = 1'b0;
          rsp_nxt = lecm_pkg::RSP_SWITCHED_OFF;
        end else if (hit[2]) begin
          led_nxt = !led_r;
          rsp_nxt = led_r ? lecm_pkg::RSP_SWITCHED_OFF : lecm_pkg::RSP_SWITCHED_ON;
        end else if (hit[3]) begin
          rsp_nxt = led_r ? lecm_pkg::RSP_STATE_ON : lecm_pkg::RSP_STATE_OFF;
        end else if (hit[4]) begin
          rsp_nxt = lecm_pkg::RSP_HELP;
        end else begin
          rsp_nxt = lecm_pkg::RSP_UNKNOWN;
        end
      end else begin
        act_nxt = lecm_pkg::ACT_PROMPT;
      end
    end else if (is_erase) begin
      if (len_r != '0) begin
        len_nxt = len_r - LW'(1);
        act_nxt = lecm_pkg::ACT_ERASE;
      end
    end else if (len_r < LW'(lecm_pkg::LINE_CAPACITY - 1)) begin
      store_wr = 1'b1;
      len_nxt  = len_r + LW'(1);
      act_nxt  = lecm_pkg::ACT_ECHO;
      echo_nxt = ch_r;
    end else begin
      len_nxt = '0;
      act_nxt = lecm_pkg::ACT_TOO_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit && store_wr) begin
      line_mem[len_r] <= ch_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rd_data_r <= line_mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      ch_r <= in_rx_char;
    end
    if (cmd.scan_start) begin
      pos_r  <= '0;
      cand_r <= '1;
    end else if (cmd.cmp && (rd_data_r != 8'd0)) begin
      pos_r  <= pos_r + LW'(1);
      cand_r <= cand_nxt;
    end
    if (cmd.emit) begin
      act_r     <= act_nxt;
      echo_r    <= echo_nxt;
      rsp_r     <= rsp_nxt;
      led_out_r <= led_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      led_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        len_r <= len_nxt;
        led_r <= led_nxt;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_action    = act_r;
  assign out_echo_char = echo_r;
  assign out_response  = rsp_r;
  assign out_led_drive = led_out_r;

endmodule

// ===== hw/rtl/line_edit_command_matcher.sv =====
// Top level of the line edit command matcher.
//
// Input channel: one received character per transaction (in_rx_char), with
// in_valid / in_stall. Result channel: one transaction per character with
// out_action, out_echo_char, out_response and out_led_drive.
// An ordinary character, backspace, delete or Enter on an empty line is loaded
// into the result register from the emit state once that register is free.
// Enter on a non-empty line scans the line store character by character
// (memory read, then a compare against all five commands in parallel),
// stopping at the end of the line or its first zero byte; a line holds at
// most 31 characters. One character is in work at a time; the next is taken
// once the previous result has been loaded into the output register, so it
// can arrive while that result still waits.
// Reset (rst_n low, synchronous) empties the line, turns the LED off and
// drops any pending result; the line store itself is not cleared.
// While out_stall is high the result holds; a finished character then waits
// in the controller and in_stall stays high until the register frees up.
`timescale 1ns / 1ps

module line_edit_command_matcher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_action,
  output logic [7:0] out_echo_char,
  output logic [2:0] out_response,
  output logic       out_led_drive
);

  lecm_pkg::lecm_cmd_t    cmd;
  lecm_pkg::lecm_status_t status;

  lecm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lecm_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_rx_char    (in_rx_char),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_echo_char (out_echo_char),
    .out_response  (out_response),
    .out_led_drive (out_led_drive)
  );

  // one character in work at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a character is in work");

  // a response is only reported for a completed line
  a_rsp_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != lecm_pkg::ACT_DONE) |-> out_response == lecm_pkg::RSP_NONE)
    else $error("response on a result that is not a completed line");

  // echo byte is zero unless the character was stored
  a_echo_only_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != lecm_pkg::ACT_ECHO) |-> out_echo_char == 8'd0)
    else $error("echo byte set on a non-echo result");

  // the result is never reloaded while the receiver stalls
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> !cmd.emit)
    else $error("result register loaded while stalled");

endmodule

// ===== tb/lecm_reply_checker.sv =====
// Checker for the line edit command matcher: tracks both channels, predicts and compares results.
`timescale 1ns / 1ps

module lecm_reply_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_rx_char,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [2:0] out_action,
  input  logic [7:0] out_echo_char,
  input  logic [2:0] out_response,
  input  logic       out_led_drive,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] echo_char;
    logic [2:0] response;
    logic       led_drive;
  } reply_t;

  string cmd_words [lecm_pkg::NUM_CMD] =
    '{"led on", "led off", "led toggle", "status", "help"};

  reply_t     replies_due [$];
  logic [7:0] line_mem [lecm_pkg::LINE_CAPACITY];
  int         line_len;
  logic       led_model;
  int         fail_tally;

  // Runs the finished line; the text ends at the first zero byte.
  function automatic logic [2:0] run_line();
    int n;
    int hit;
    bit same;
    n = 0;
    hit = lecm_pkg::NUM_CMD;
    while (n < line_len && line_mem[n] != 8'd0) n++;
    if (n == 0) return lecm_pkg::RSP_NONE;
    for (int k = 0; k < lecm_pkg::NUM_CMD; k++) begin
      if (hit == lecm_pkg::NUM_CMD && cmd_words[k].len() == n) begin
        same = 1'b1;
        for (int i = 0; i < n; i++)
          if (line_mem[i] != cmd_words[k][i]) same = 1'b0;
        if (same) hit = k;
      end
    end
    case (hit)
      lecm_pkg::CMD_LED_ON: begin
        led_model = 1'b1;
        return lecm_pkg::RSP_SWITCHED_ON;
      end
      lecm_pkg::CMD_LED_OFF: begin
        led_model = 1'b0;
        return lecm_pkg::RSP_SWITCHED_OFF;
      end
      lecm_pkg::CMD_LED_TOGGLE: begin
        led_model = ~led_model;
        return led_model ? lecm_pkg::RSP_SWITCHED_ON : lecm_pkg::RSP_SWITCHED_OFF;
      end
      lecm_pkg::CMD_STATUS: return led_model ? lecm_pkg::RSP_STATE_ON : lecm_pkg::RSP_STATE_OFF;
      lecm_pkg::CMD_HELP:   return lecm_pkg::RSP_HELP;
      default:              return lecm_pkg::RSP_UNKNOWN;
    endcase
  endfunction

  function automatic reply_t next_reply(input logic [7:0] c);
    reply_t r;
    r = '{lecm_pkg::ACT_NONE, 8'd0, lecm_pkg::RSP_NONE, 1'b0};
    if (c == lecm_pkg::CH_CR || c == lecm_pkg::CH_LF) begin
      if (line_len > 0) begin
        r.response = run_line();
        line_len = 0;
        r.action = lecm_pkg::ACT_DONE;
      end else begin
        r.action = lecm_pkg::ACT_PROMPT;
      end
    end else if (c == lecm_pkg::CH_BS || c == lecm_pkg::CH_DEL) begin
      if (line_len > 0) begin
        line_len--;
        r.action = lecm_pkg::ACT_ERASE;
      end
    end else if (line_len < lecm_pkg::LINE_CAPACITY - 1) begin
      line_mem[line_len] = c;
      line_len++;
      r.action = lecm_pkg::ACT_ECHO;
      r.echo_char = c;
    end else begin
      // full line: character dropped, line cleared
      line_len = 0;
      r.action = lecm_pkg::ACT_TOO_LONG;
    end
    r.led_drive = led_model;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d got %0d", $time, what, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      replies_due.delete();
      line_len = 0;
      led_model = 1'b0;
      fail_tally = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (replies_due.size() == 0) begin
          $display("%0t: result with nothing pending, expected none got %s%0d %0d %0d %0d",
                   $time, "action/echo/rsp/led=", out_action, out_echo_char,
                   out_response, out_led_drive);
          fail_tally++;
        end else begin
          want = replies_due.pop_front();
          check_field("action", 8'(want.action), 8'(out_action));
          check_field("echo_char", want.echo_char, out_echo_char);
          check_field("response", 8'(want.response), 8'(out_response));
          check_field("led_drive", 8'(want.led_drive), 8'(out_led_drive));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0)
        replies_due.push_back(next_reply(in_rx_char));
    end
    mismatches  <= fail_tally;
    outstanding <= replies_due.size();
  end

endmodule

// ===== tb/tb_line_edit_command_matcher.sv =====
// Testbench top for the line edit command matcher: character stimulus, receiver stalls, verdict.
`timescale 1ns / 1ps

module tb_line_edit_command_matcher;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 5;
  localparam int TARGET_CHARS   = 1050;
  localparam int LONG_HOLD      = 400;
  localparam int SETTLE_CYCLES  = 100;
  localparam int TIMEOUT_CYCLES = 1_000_000;

  // receiver stall styles
  localparam int RX_FREE  = 0;
  localparam int RX_LIGHT = 1;
  localparam int RX_HEAVY = 2;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_char = 8'd0;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [2:0] out_action;
  logic [7:0] out_echo_char;
  logic [2:0] out_response;
  logic       out_led_drive;
  int         mismatches;
  int         outstanding;

  int chars_sent = 0;
  int burst_left = 0;
  int hold_ask   = 0;
  int hold_seen  = 0;
  int hold_left  = 0;
  int rx_style   = RX_FREE;
  int style_left = 0;

  string cmd_words [lecm_pkg::NUM_CMD] =
    '{"led on", "led off", "led toggle", "status", "help"};

  always #(CLK_PERIOD / 2) clk = ~clk;

  line_edit_command_matcher dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_char    (in_rx_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_echo_char (out_echo_char),
    .out_response  (out_response),
    .out_led_drive (out_led_drive)
  );

  lecm_reply_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_rx_char    (in_rx_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_action    (out_action),
    .out_echo_char (out_echo_char),
    .out_response  (out_response),
    .out_led_drive (out_led_drive),
    .mismatches    (mismatches),
    .outstanding   (outstanding)
  );

  // Receiver: random stall styles, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_seen != hold_ask) begin
      hold_seen <= hold_ask;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else begin
      if (style_left == 0) begin
        rx_style   <= $urandom_range(RX_FREE, RX_HEAVY);
        style_left <= $urandom_range(40, 250);
      end else begin
        style_left <= style_left - 1;
      end
      case (rx_style)
        RX_FREE:  out_stall <= 1'b0;
        RX_LIGHT: out_stall <= ($urandom_range(0, 99) < 30);
        default:  out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_char(input logic [7:0] c);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    in_valid   <= 1'b1;
    in_rx_char <= c;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    burst_left--;
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_enter();
    send_char($urandom_range(0, 1) ? lecm_pkg::CH_CR : lecm_pkg::CH_LF);
  endtask

  // Sender pause: drop valid and wait until every result is back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Any byte that is stored as text (no line end, no erase).
  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == lecm_pkg::CH_CR || c == lecm_pkg::CH_LF ||
           c == lecm_pkg::CH_BS || c == lecm_pkg::CH_DEL);
    return c;
  endfunction

  // A command word, mostly intact, sometimes edited, damaged or cut by a zero byte.
  task automatic send_command_line();
    string w;
    int    pick;
    int    pos;
    w    = cmd_words[$urandom_range(0, lecm_pkg::NUM_CMD - 1)];
    pick = $urandom_range(0, 9);
    pos  = $urandom_range(0, w.len() - 1);
    for (int i = 0; i < w.len(); i++) begin
      if (pick == 1 && i == pos) begin
        send_char(plain_char());
        send_char($urandom_range(0, 1) ? lecm_pkg::CH_BS : lecm_pkg::CH_DEL);
      end
      if (pick == 2 && i == pos)
        send_char(plain_char());
      else if (!(pick == 3 && i == w.len() - 1))
        send_char(w[i]);
    end
    if (pick == 4) send_char(plain_char());
    if (pick == 5) begin
      send_char(8'd0);
      repeat ($urandom_range(0, 4)) send_char(plain_char());
    end
    send_enter();
  endtask

  task automatic send_junk_line();
    if ($urandom_range(0, 4) == 0) send_char(8'd0);
    repeat ($urandom_range(0, 6)) send_char(plain_char());
    send_enter();
  endtask

  // Fill the line to capacity and run past it, sometimes erasing at the full mark.
  task automatic send_overflow_line();
    repeat (lecm_pkg::LINE_CAPACITY - 1) send_char(plain_char());
    if ($urandom_range(0, 1)) begin
      send_char(lecm_pkg::CH_BS);
      send_char(plain_char());
    end
    repeat ($urandom_range(1, 3)) send_char(plain_char());
    send_enter();
  endtask

  initial begin
    int shape;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty-line handling, zero and 0xFF bytes, erase, unknown text, two commands
    send_char(lecm_pkg::CH_LF);
    send_char(lecm_pkg::CH_BS);
    send_char(lecm_pkg::CH_DEL);
    send_char(8'h00);
    send_char(lecm_pkg::CH_CR);
    send_char(8'hFF);
    send_char("a");
    send_char(lecm_pkg::CH_DEL);
    send_char(lecm_pkg::CH_CR);
    send_text("help");
    send_char(lecm_pkg::CH_LF);
    send_text("status");
    send_char(lecm_pkg::CH_CR);
    wait_idle();

    while (chars_sent < TARGET_CHARS) begin
      if (chars_sent >= TARGET_CHARS / 2 && hold_ask == 0) hold_ask <= 1;
      shape = $urandom_range(0, 99);
      if (shape < 62)
        send_command_line();
      else if (shape < 75)
        send_junk_line();
      else if (shape < 82)
        send_overflow_line();
      else
        repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)));
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      if (outstanding != 0) $display("%0t: %0d results never arrived", $time, outstanding);
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("%0t: timeout", $time);
    $display("TEST FAILED");
    $finish;
  end

endmodule
